FILE: hw/rtl/gbn_pkg.sv
// Shared types and codes for the go-back-n sender window.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package gbn_pkg;

   localparam int SEQ_W = 16;
   localparam int CNT_W = 7;
   localparam int CC_W  = 5;

   typedef enum logic [1:0] {
      REQ_OFFER = 2'd0,
      REQ_ACK   = 2'd1,
      REQ_CLOSE = 2'd2,
      REQ_TICK  = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      ACT_SEND    = 3'd0,
      ACT_REFUSED = 3'd1,
      ACT_RESEND  = 3'd2,
      ACT_NOTHING = 3'd3,
      ACT_CLOSE   = 3'd4,
      ACT_DONE    = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      KIND_ACK   = 2'd0,
      KIND_DATA  = 2'd1,
      KIND_FINAL = 2'd2
   } kind_type;

   typedef enum logic [0:0] {
      CSR_WINDOW  = 1'b0,
      CSR_TIMEOUT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   typedef struct packed {
      logic step;   // accepted item is evaluated
      logic emit;   // next resend of the run goes to the output register
   } cmd_type;

   typedef struct packed {
      logic start_run;  // item under evaluation starts a resend run
      logic run_last;   // resend being emitted closes the run
   } status_type;

endpackage

`default_nettype wire

FILE: hw/rtl/gbn_if.sv
// Handshake channels of the go-back-n sender window.
// Depends on gbn_pkg for field widths.
`default_nettype none

interface gbn_req_if import gbn_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       req_type;
   logic             is_final_chunk;
   logic [SEQ_W-1:0] ack_seq;

   modport source (output valid, req_type, is_final_chunk, ack_seq, input ready);
   modport sink   (input valid, req_type, is_final_chunk, ack_seq, output ready);
endinterface

interface gbn_rsp_if import gbn_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [2:0]       action;
   logic [SEQ_W-1:0] seq_out;
   logic [1:0]       frame_kind;
   logic             last_of_run;
   logic             timer_active;
   logic [CNT_W-1:0] outstanding;

   modport source (output valid, action, seq_out, frame_kind, last_of_run, timer_active,
                   outstanding, input ready);
   modport sink   (input valid, action, seq_out, frame_kind, last_of_run, timer_active,
                   outstanding, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/gbn_dp.sv
// Datapath: session state, config registers, resend run counter, result register.
// Depends on gbn_pkg; driven by gbn_ctrl through cmd/status.
`default_nettype none

module gbn_dp import gbn_pkg::*; #(
   parameter int MAX_WINDOW  = 64,
   parameter int CLOSE_TICKS = 20
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [0:0]       csr_index,
   input  wire logic [SEQ_W-1:0] csr_wdata,
   input  wire logic [1:0]       in_type,
   input  wire logic             in_final,
   input  wire logic [SEQ_W-1:0] in_ack,
   input  wire cmd_type          cmd,
   output status_type            status,
   output logic [2:0]            out_action,
   output logic [SEQ_W-1:0]      out_seq,
   output logic [1:0]            out_kind,
   output logic                  out_last,
   output logic                  out_timer,
   output logic [CNT_W-1:0]      out_outstanding
);

   localparam logic [CNT_W-1:0] MaxWin   = CNT_W'(MAX_WINDOW);
   localparam logic [CC_W-1:0]  CloseEnd = CC_W'(CLOSE_TICKS);

   logic [CNT_W-1:0] window_ff, window_in;
   logic [SEQ_W-1:0] timeout_ff, timeout_in;
   logic [SEQ_W-1:0] base_ff, base_in;
   logic [SEQ_W-1:0] next_ff, next_in;
   logic             timer_ff, timer_in;
   logic [SEQ_W-1:0] tick_ff, tick_in;
   logic [SEQ_W-1:0] fseq_ff, fseq_in;
   logic             fsent_ff, fsent_in;
   logic [CC_W-1:0]  cc_ff, cc_in;
   logic [CNT_W-1:0] ridx_ff, ridx_in;
   logic [CNT_W-1:0] rlen_ff, rlen_in;

   logic [2:0]       act_ff, act_in;
   logic [SEQ_W-1:0] seq_ff, seq_in;
   logic [1:0]       kind_ff, kind_in;
   logic             last_ff, last_in;
   logic             tmr_ff, tmr_in;
   logic [CNT_W-1:0] outs_ff, outs_in;

   logic [SEQ_W-1:0] pend;
   logic [CNT_W-1:0] eff_win;
   logic [SEQ_W-1:0] limit;
   logic [SEQ_W-1:0] nb, adv, tk, rseq;
   logic [CC_W-1:0]  cc_nx;
   logic [CNT_W-1:0] run_n;
   logic             start_run, load;

   assign pend    = next_ff - base_ff;
   assign eff_win = (window_ff == '0) ? CNT_W'(1) :
                    ((window_ff > MaxWin) ? MaxWin : window_ff);
   assign limit   = (timeout_ff == '0) ? SEQ_W'(1) : timeout_ff;
   assign nb      = in_ack + SEQ_W'(1);
   assign adv     = nb - base_ff;
   assign tk      = (tick_ff == '1) ? tick_ff : tick_ff + SEQ_W'(1);
   assign cc_nx   = (cc_ff < CloseEnd) ? cc_ff + CC_W'(1) : cc_ff;
   assign run_n   = (pend > SEQ_W'(MAX_WINDOW)) ? MaxWin : pend[CNT_W-1:0];
   assign rseq    = base_ff + SEQ_W'(ridx_ff);

   assign start_run = (in_type == REQ_TICK) &&
                      !(fsent_ff && pend == '0 && cc_nx >= CloseEnd) &&
                      timer_ff && tk >= limit && run_n != '0;

   assign status.start_run = start_run;
   assign status.run_last  = (ridx_ff + CNT_W'(1)) == rlen_ff;
   assign load = (cmd.step && !start_run) || cmd.emit;

   always_comb begin
      window_in  = window_ff;
      timeout_in = timeout_ff;
      base_in    = base_ff;
      next_in    = next_ff;
      timer_in   = timer_ff;
      tick_in    = tick_ff;
      fseq_in    = fseq_ff;
      fsent_in   = fsent_ff;
      cc_in      = cc_ff;
      ridx_in    = ridx_ff;
      rlen_in    = rlen_ff;
      act_in     = ACT_NOTHING;
      seq_in     = '0;
      kind_in    = KIND_ACK;
      last_in    = 1'b1;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WINDOW:  window_in  = csr_wdata[CNT_W-1:0];
            CSR_TIMEOUT: timeout_in = csr_wdata;
            default:     timeout_in = timeout_ff;
         endcase
      end

      if (cmd.step) begin
         unique case (in_type)
            REQ_OFFER: begin
               if (fsent_ff || pend >= SEQ_W'(eff_win)) begin
                  act_in = ACT_REFUSED;
               end else begin
                  if (base_ff == next_ff) begin
                     timer_in = 1'b1;
                     tick_in  = '0;
                  end
                  next_in = next_ff + SEQ_W'(1);
                  if (in_final) begin
                     fseq_in  = next_ff;
                     fsent_in = 1'b1;
                  end
                  act_in  = ACT_SEND;
                  seq_in  = next_ff;
                  kind_in = in_final ? KIND_FINAL : KIND_DATA;
               end
            end
            REQ_ACK: begin
               if (adv <= pend) begin
                  base_in  = nb;
                  timer_in = (nb != next_ff);
                  tick_in  = '0;
               end
            end
            REQ_CLOSE: begin
               base_in  = SEQ_W'(1);
               next_in  = SEQ_W'(1);
               timer_in = 1'b0;
               tick_in  = '0;
               fseq_in  = '0;
               fsent_in = 1'b0;
               cc_in    = '0;
               act_in   = ACT_CLOSE;
            end
            REQ_TICK: begin
               if (fsent_ff && pend == '0) begin
                  cc_in = cc_nx;
               end
               if (fsent_ff && pend == '0 && cc_nx >= CloseEnd) begin
                  act_in = ACT_DONE;
               end else if (timer_ff) begin
                  if (tk >= limit) begin
                     tick_in = '0;
                     ridx_in = '0;
                     rlen_in = run_n;
                  end else begin
                     tick_in = tk;
                  end
               end
            end
            default: act_in = ACT_NOTHING;
         endcase
      end

      if (cmd.emit) begin
         act_in  = ACT_RESEND;
         seq_in  = rseq;
         kind_in = (fsent_ff && rseq == fseq_ff) ? KIND_FINAL : KIND_DATA;
         last_in = status.run_last;
         ridx_in = ridx_ff + CNT_W'(1);
      end

      tmr_in  = timer_in;
      outs_in = CNT_W'(next_in - base_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= CNT_W'(4);
         timeout_ff <= SEQ_W'(2);
         base_ff    <= SEQ_W'(1);
         next_ff    <= SEQ_W'(1);
         timer_ff   <= 1'b0;
         tick_ff    <= '0;
         fseq_ff    <= '0;
         fsent_ff   <= 1'b0;
         cc_ff      <= '0;
         ridx_ff    <= '0;
         rlen_ff    <= '0;
      end else begin
         window_ff  <= window_in;
         timeout_ff <= timeout_in;
         base_ff    <= base_in;
         next_ff    <= next_in;
         timer_ff   <= timer_in;
         tick_ff    <= tick_in;
         fseq_ff    <= fseq_in;
         fsent_ff   <= fsent_in;
         cc_ff      <= cc_in;
         ridx_ff    <= ridx_in;
         rlen_ff    <= rlen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         act_ff  <= act_in;
         seq_ff  <= seq_in;
         kind_ff <= kind_in;
         last_ff <= last_in;
         tmr_ff  <= tmr_in;
         outs_ff <= outs_in;
      end
   end

   assign out_action      = act_ff;
   assign out_seq         = seq_ff;
   assign out_kind        = kind_ff;
   assign out_last        = last_ff;
   assign out_timer       = tmr_ff;
   assign out_outstanding = outs_ff;

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend <= SEQ_W'(MAX_WINDOW)) else $error("outstanding count beyond window");
   a_emit_in_run: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> ridx_ff < rlen_ff) else $error("resend past end of run");
   a_timer_pend: assert property (@(posedge clock) disable iff (reset)
      timer_ff |-> pend != '0) else $error("timer running with nothing outstanding");

endmodule

`default_nettype wire

FILE: hw/rtl/gbn_ctrl.sv
// Controller: accepts items, sequences resend runs, owns the result valid flag.
// Depends on gbn_pkg; commands gbn_dp.
`default_nettype none

module gbn_ctrl import gbn_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   input  wire status_type status,
   output cmd_type   cmd
);

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;
   logic      can_load, accept, load;

   assign can_load  = !valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && can_load;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd.step = 1'b0;
      cmd.emit = 1'b0;
      load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.step = accept;
            if (accept) begin
               if (status.start_run) begin
                  state_in = ST_RUN;
               end else begin
                  load = 1'b1;
               end
            end
         end
         ST_RUN: begin
            if (can_load) begin
               cmd.emit = 1'b1;
               load     = 1'b1;
               if (status.run_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      valid_in = load ? 1'b1 : (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;

   a_run_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> !req_ready) else $error("item taken during resend run");
   a_run_entry: assert property (@(posedge clock) disable iff (reset)
      (accept && status.start_run) |=> (state_ff == ST_RUN) && !valid_ff)
      else $error("resend run not entered cleanly");
   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      !(cmd.step && cmd.emit)) else $error("step and emit together");

endmodule

`default_nettype wire

FILE: hw/rtl/go_back_n_sender_window_top.sv
// Top level of the go-back-n sender window: controller plus datapath.
// Depends on gbn_pkg, gbn_if, gbn_ctrl and gbn_dp.
//
//   Channel  Dir  Handshake        Carries
//   req_ch   in   valid/ready      req_type, is_final_chunk, ack_seq
//   rsp_ch   out  valid/ready      action, seq_out, frame_kind, last_of_run,
//                                  timer_active, outstanding
//   csr_*    in   write enable     index 0 window_size, 1 timeout_ticks
//
// One item per cycle while idle and the output can take it; its result is registered
// as it is accepted. A tick that times out starts a run of resends instead, one per
// cycle while the output can take them; the run counter walks the outstanding
// sequence numbers. Reset is synchronous and restores session and config defaults.
// A stalled result holds; a new item is taken in the cycle the result leaves.
`default_nettype none

module go_back_n_sender_window_top import gbn_pkg::*; #(
   parameter int MAX_WINDOW  = 64,
   parameter int CLOSE_TICKS = 20
) (
   input  wire logic             clock,
   input  wire logic             reset,
   gbn_req_if.sink               req_ch,
   gbn_rsp_if.source             rsp_ch,
   input  wire logic             csr_wr_en,
   input  wire logic [0:0]       csr_index,
   input  wire logic [SEQ_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   gbn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   gbn_dp #(
      .MAX_WINDOW  (MAX_WINDOW),
      .CLOSE_TICKS (CLOSE_TICKS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .in_type         (req_ch.req_type),
      .in_final        (req_ch.is_final_chunk),
      .in_ack          (req_ch.ack_seq),
      .cmd             (cmd),
      .status          (status),
      .out_action      (rsp_ch.action),
      .out_seq         (rsp_ch.seq_out),
      .out_kind        (rsp_ch.frame_kind),
      .out_last        (rsp_ch.last_of_run),
      .out_timer       (rsp_ch.timer_active),
      .out_outstanding (rsp_ch.outstanding)
   );

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for go_back_n_sender_window_top: directed and random event streams,
// with a scoreboard class that predicts every result item and checks them in order.
// Depends on gbn_pkg, gbn_if and the RTL of the block.

import gbn_pkg::*;

localparam int WINDOW_CAP  = 64;
localparam int CLOSE_LIMIT = 20;

typedef struct packed {
   req_code_type     code;
   logic             fin_flag;
   logic [SEQ_W-1:0] ack;
} event_item_type;

typedef struct packed {
   action_type       action;
   logic [SEQ_W-1:0] seq;
   kind_type         kind;
   logic             last;
   logic             timer;
   logic [CNT_W-1:0] outstanding;
} send_result_type;

class gbn_send_ledger;
   logic [6:0]       win_reg;
   logic [15:0]      tmo_reg;
   logic [SEQ_W-1:0] base, nxt, ticks, fin_seq;
   logic             timer_on, fin_sent;
   logic [CC_W-1:0]  close_cnt;
   send_result_type  expected_q[$];
   int               errors;

   function new();
      win_reg = 7'd4;
      tmo_reg = 16'd2;
      errors  = 0;
      clear_session();
   endfunction

   function void clear_session();
      base      = 16'd1;
      nxt       = 16'd1;
      timer_on  = 1'b0;
      ticks     = 16'd0;
      fin_seq   = 16'd0;
      fin_sent  = 1'b0;
      close_cnt = '0;
   endfunction

   function logic [SEQ_W-1:0] in_flight();
      return nxt - base;
   endfunction

   function int unsigned window_limit();
      if (win_reg == 0) return 1;
      if (win_reg > WINDOW_CAP) return WINDOW_CAP;
      return 32'(win_reg);
   endfunction

   function void write_reg(csr_index_type idx, logic [15:0] v);
      if (idx == CSR_WINDOW) win_reg = v[6:0];
      else tmo_reg = v;
   endfunction

   function void post(action_type a, logic [SEQ_W-1:0] s, kind_type k, logic last);
      send_result_type r;
      logic [SEQ_W-1:0] p;
      p = in_flight();
      r.action      = a;
      r.seq         = s;
      r.kind        = k;
      r.last        = last;
      r.timer       = timer_on;
      r.outstanding = (p > 127) ? 7'd127 : p[6:0];
      expected_q.push_back(r);
   endfunction

   // Accepted event: update the session and queue the result items it causes.
   function void note_event(event_item_type it);
      logic [SEQ_W-1:0] s, nb, adv, lim;
      int unsigned n;
      kind_type k;
      case (it.code)
         REQ_OFFER: begin
            if (fin_sent || in_flight() >= window_limit()) begin
               post(ACT_REFUSED, '0, KIND_ACK, 1'b1);
            end else begin
               s = nxt;
               if (base == nxt) begin
                  timer_on = 1'b1;
                  ticks    = '0;
               end
               nxt = nxt + 16'd1;
               if (it.fin_flag) begin
                  fin_seq  = s;
                  fin_sent = 1'b1;
               end
               post(ACT_SEND, s, it.fin_flag ? KIND_FINAL : KIND_DATA, 1'b1);
            end
         end
         REQ_ACK: begin
            nb  = it.ack + 16'd1;
            adv = nb - base;
            if (adv <= in_flight()) begin
               base     = nb;
               timer_on = (base != nxt);
               ticks    = '0;
            end
            post(ACT_NOTHING, '0, KIND_ACK, 1'b1);
         end
         REQ_CLOSE: begin
            clear_session();
            post(ACT_CLOSE, '0, KIND_ACK, 1'b1);
         end
         default: begin
            if (fin_sent && in_flight() == 0) begin
               if (close_cnt < CLOSE_LIMIT) close_cnt = close_cnt + 1'b1;
               if (close_cnt >= CLOSE_LIMIT) begin
                  post(ACT_DONE, '0, KIND_ACK, 1'b1);
                  return;
               end
            end
            if (timer_on) begin
               lim = (tmo_reg == 0) ? 16'd1 : tmo_reg;
               if (ticks != 16'hFFFF) ticks = ticks + 16'd1;
               if (ticks >= lim) begin
                  n = (in_flight() > WINDOW_CAP) ? WINDOW_CAP : in_flight();
                  ticks = '0;
                  if (n > 0) begin
                     for (int unsigned i = 0; i < n; i++) begin
                        s = base + i[15:0];
                        k = (fin_sent && s == fin_seq) ? KIND_FINAL : KIND_DATA;
                        post(ACT_RESEND, s, k, i + 1 == n);
                     end
                     return;
                  end
               end
            end
            post(ACT_NOTHING, '0, KIND_ACK, 1'b1);
         end
      endcase
   endfunction

   function void check_result(send_result_type got);
      send_result_type want;
      if (expected_q.size() == 0) begin
         if (errors < 10)
            $display("unexpected result: act %0d seq %0d kind %0d last %b tmr %b out %0d",
                     got.action, got.seq, got.kind, got.last, got.timer, got.outstanding);
         errors++;
         return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
         if (errors < 10) begin
            $display("mismatch: expected act %0d seq %0d kind %0d last %b tmr %b out %0d",
                     want.action, want.seq, want.kind, want.last, want.timer,
                     want.outstanding);
            $display("          got      act %0d seq %0d kind %0d last %b tmr %b out %0d",
                     got.action, got.seq, got.kind, got.last, got.timer, got.outstanding);
         end
         errors++;
      end
   endfunction
endclass

module testbench;
   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_wr_en;
   logic [0:0]       csr_index;
   logic [SEQ_W-1:0] csr_wdata;

   gbn_req_if req_ch();
   gbn_rsp_if rsp_ch();

   go_back_n_sender_window_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   gbn_send_ledger ledger = new();
   bit sender_eager = 1'b0;
   bit sink_eager   = 1'b0;
   int items_sent   = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("[go_back_n_sender_window_top] ERROR");
      $finish;
   end

   // result side: random stall per item, check at the accepting edge
   initial begin
      send_result_type got;
      int stall;
      rsp_ch.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         stall = sink_eager ? 0 : $urandom_range(0, 15);
         repeat (stall) begin
            @(negedge clock);
            rsp_ch.ready = 1'b0;
         end
         @(negedge clock);
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         got.action      = action_type'(rsp_ch.action);
         got.seq         = rsp_ch.seq_out;
         got.kind        = kind_type'(rsp_ch.frame_kind);
         got.last        = rsp_ch.last_of_run;
         got.timer       = rsp_ch.timer_active;
         got.outstanding = rsp_ch.outstanding;
         ledger.check_result(got);
      end
   end

   task automatic push(req_code_type code, logic fin, logic [SEQ_W-1:0] ack);
      event_item_type it;
      int gap;
      it  = '{code, fin, ack};
      gap = sender_eager ? 0 : $urandom_range(0, 15);
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
      end
      @(negedge clock);
      req_ch.valid          = 1'b1;
      req_ch.req_type       = code;
      req_ch.is_final_chunk = fin;
      req_ch.ack_seq        = ack;
      do @(posedge clock); while (!req_ch.ready);
      ledger.note_event(it);
      items_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (ledger.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_regs(logic [15:0] win, logic [15:0] tmo);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = CSR_WINDOW;
      csr_wdata = win;
      @(posedge clock);
      ledger.write_reg(CSR_WINDOW, win);
      @(negedge clock);
      csr_index = CSR_TIMEOUT;
      csr_wdata = tmo;
      @(posedge clock);
      ledger.write_reg(CSR_TIMEOUT, tmo);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic random_event();
      int r;
      logic [SEQ_W-1:0] a;
      r = $urandom_range(0, 99);
      if (r < 42) begin
         push(REQ_OFFER, $urandom_range(0, 9) == 0, 16'($urandom));
      end else if (r < 66) begin
         if ($urandom_range(0, 4) != 0)
            a = ledger.base - 16'd1 + 16'($urandom_range(0, ledger.in_flight()));
         else
            a = 16'($urandom);
         push(REQ_ACK, 1'($urandom_range(0, 1)), a);
      end else if (r < 97) begin
         push(REQ_TICK, 1'($urandom_range(0, 1)), 16'($urandom));
      end else begin
         push(REQ_CLOSE, 1'($urandom_range(0, 1)), 16'($urandom));
      end
   endtask

   // a run of mixed events, then often a full drain of the window and the close countdown
   task automatic session_burst();
      repeat ($urandom_range(4, 20)) random_event();
      if (ledger.fin_sent && $urandom_range(0, 1)) begin
         push(REQ_ACK, 1'b0, ledger.nxt - 16'd1);
         repeat ($urandom_range(18, 23)) push(REQ_TICK, 1'b0, 16'($urandom));
         if ($urandom_range(0, 1)) push(REQ_CLOSE, 1'b0, 16'($urandom));
      end else if (ledger.fin_sent && $urandom_range(0, 2) == 0) begin
         push(REQ_CLOSE, 1'b0, 16'($urandom));
      end
   endtask

   initial begin
      logic [15:0] win_vals[8];
      logic [15:0] tmo_vals[8];
      logic [15:0] w, t;
      int goal;
      win_vals = '{16'd1, 16'd64, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd7, 16'd64};
      tmo_vals = '{16'd1, 16'd3, 16'd0, 16'd1, 16'd0, 16'd0, 16'hFFFF, 16'd2};
      req_ch.valid          = 1'b0;
      req_ch.req_type       = REQ_OFFER;
      req_ch.is_final_chunk = 1'b0;
      req_ch.ack_seq        = '0;
      csr_wr_en             = 1'b0;
      csr_index             = CSR_WINDOW;
      csr_wdata             = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: default window 4, timeout 2
      push(REQ_ACK,   1'b0, 16'd0);        // ack at base-1, nothing outstanding
      push(REQ_TICK,  1'b0, 16'd0);        // timer idle
      repeat (4) push(REQ_OFFER, 1'b0, 16'd0);
      push(REQ_OFFER, 1'b0, 16'd0);        // window full: refused
      push(REQ_ACK,   1'b1, 16'hFFFF);     // outside window: ignored
      push(REQ_TICK,  1'b0, 16'd0);
      push(REQ_TICK,  1'b0, 16'd0);        // timeout: resend run of four
      push(REQ_ACK,   1'b0, 16'd2);
      push(REQ_OFFER, 1'b1, 16'd0);        // final chunk
      push(REQ_OFFER, 1'b0, 16'd0);        // after final: refused
      push(REQ_TICK,  1'b0, 16'd0);
      push(REQ_TICK,  1'b0, 16'd0);        // resend run ending in final data
      push(REQ_ACK,   1'b0, 16'd5);        // all acked, timer stops
      push(REQ_TICK,  1'b0, 16'd0);        // closing countdown starts
      push(REQ_CLOSE, 1'b1, 16'hFFFF);
      push(REQ_ACK,   1'b0, 16'h8000);
      push(REQ_OFFER, 1'b1, 16'h7FFF);
      push(REQ_ACK,   1'b1, 16'd1);

      for (int i = 0; i < 8; i++) begin
         drain_results();
         w = (i == 4 || i == 5) ? 16'($urandom_range(2, 63)) : win_vals[i];
         t = (i == 4 || i == 5) ? 16'($urandom_range(2, 6)) : tmo_vals[i];
         write_regs(w, t);
         sender_eager = (i % 4 == 1);
         sink_eager   = (i % 4 == 2);
         goal = items_sent + 25;
         while (items_sent < goal) session_burst();
      end
      drain_results();
      repeat (8) @(posedge clock);

      if (ledger.errors == 0 && ledger.expected_q.size() == 0) begin
         $display("[go_back_n_sender_window_top] OK");
      end else begin
         $display("[go_back_n_sender_window_top] ERROR");
      end
      $finish;
   end
endmodule
